/* rtl/snm_pkg.sv */
`default_nettype none

package snm_pkg;

    // default build sizes
    localparam int DATA_WIDTH_DEF    = 16;
    localparam int ACC_WIDTH_DEF     = 48;
    localparam int SIG_DEPTH_DEF     = 256;

    // activation output format, signed Q1.15
    localparam int ACT_W             = 16;
    localparam int SIG_W             = 17;     // table value, unsigned Q.16 up to 1.0
    localparam int LUT_SHIFT         = 28;     // interpolation fraction bits
    localparam int QUEUE_DEPTH       = 4;

    localparam logic MODE_PLAIN      = 1'b0;
    localparam logic MODE_CENTRED    = 1'b1;

    // shift-subtract divide, only used while building the table at elaboration
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den) begin
                rem  = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-t), t and result unsigned Q.31
    function automatic longint unsigned exp_neg_q31(input longint unsigned t);
        longint unsigned u;
        longint unsigned y;
        longint unsigned term;
        u    = t >> 4;
        y    = 64'd1 << 31;
        term = 64'd1 << 31;
        for (int n = 1; n <= 12; n++) begin
            term = udiv((term * u) >> 31, longint'(n));
            if ((n % 2) == 1) begin
                y = y - term;
            end else begin
                y = y + term;
            end
        end
        for (int k = 0; k < 4; k++) begin
            y = (y * y + (64'd1 << 30)) >> 31;
        end
        return y;
    endfunction

    // sigmoid at grid point i of a table over [-8,8), unsigned Q.16
    function automatic logic [SIG_W-1:0] sig_entry(input int i, input int depth);
        longint unsigned g;
        longint unsigned centre;
        longint unsigned e;
        longint unsigned den;
        longint unsigned v;
        centre = 64'd8 << 31;
        g      = udiv(longint'(i) << 35, longint'(depth));
        if (g >= centre) begin
            e   = exp_neg_q31(g - centre);
            den = (64'd1 << 31) + e;
            v   = udiv((64'd1 << 47) + (den >> 1), den);
        end else begin
            e   = exp_neg_q31(centre - g);
            den = (64'd1 << 31) + e;
            v   = udiv((e << 16) + (den >> 1), den);
        end
        return v[SIG_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/snm_front.sv */
`default_nettype none

module snm_front #(
    parameter int DATA_WIDTH = snm_pkg::DATA_WIDTH_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [DATA_WIDTH-1:0]      i_feature,
    input  wire  [DATA_WIDTH-1:0]      i_weight,
    input  wire                        i_bias_item,
    output logic                       o_push,
    output logic [2*DATA_WIDTH:0]      o_push_data,   // {bias, addend}
    input  wire                        i_full
);
    import snm_pkg::*;

    localparam int F  = DATA_WIDTH - 4;
    localparam int AW = 2 * DATA_WIDTH;

    logic          r_valid;
    logic          r_bias;
    logic [AW-1:0] r_addend;
    logic [AW-1:0] n_addend;
    logic          w_take;

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign w_take  = i_valid && o_ready;

    // bias item: weight aligned to the accumulator, else the exact product
    always_comb begin
        if (i_bias_item) begin
            n_addend = AW'($signed(i_weight)) << F;
        end else begin
            n_addend = $signed(i_feature) * $signed(i_weight);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_addend <= n_addend;
            r_bias   <= i_bias_item;
        end
    end

    assign o_push_data = {r_bias, r_addend};

endmodule

`default_nettype wire

/* rtl/snm_queue.sv */
`default_nettype none

module snm_queue #(
    parameter int WIDTH = 33,
    parameter int DEPTH = snm_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire  [WIDTH-1:0]  i_push_data,
    output logic              o_full,
    input  wire               i_pop,
    output logic              o_empty,
    output logic [WIDTH-1:0]  o_head
);
    import snm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/snm_back.sv */
`default_nettype none

module snm_back #(
    parameter int DATA_WIDTH          = snm_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH           = snm_pkg::ACC_WIDTH_DEF,
    parameter int SIGMOID_TABLE_DEPTH = snm_pkg::SIG_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_mode,
    input  wire  [2*DATA_WIDTH:0]        i_head,
    input  wire                          i_empty,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [snm_pkg::ACT_W-1:0]    o_activation,
    output logic [ACC_WIDTH-1:0]         o_pre_activation,
    output logic                         o_sum_saturated
);
    import snm_pkg::*;

    localparam int F        = DATA_WIDTH - 4;
    localparam int ACC_FRAC = 2 * F;
    localparam int AW       = 2 * DATA_WIDTH;
    localparam int SW       = ((ACC_WIDTH > AW) ? ACC_WIDTH : AW) + 1;
    localparam int CW       = ((ACC_WIDTH > ACC_FRAC + 5) ? ACC_WIDTH : ACC_FRAC + 5) + 1;
    localparam int PW       = ACC_FRAC + 4;
    localparam int DEPTH    = SIGMOID_TABLE_DEPTH;
    localparam int DBW      = $clog2(DEPTH + 1);
    localparam int MW       = SIG_W + LUT_SHIFT + 1;

    localparam logic [SW-1:0] SUM_MAX = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [SW-1:0] SUM_MIN = {{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [CW-1:0] LIM     = CW'(1) << (ACC_FRAC + 3);
    localparam logic [CW-1:0] NEG_LIM = ~LIM + CW'(1);
    localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(1) << 16;

    // interpolation table, built at elaboration
    logic [SIG_W-1:0] w_rom [DEPTH+1];
    for (genvar g = 0; g <= DEPTH; g++) begin : g_rom
        localparam logic [SIG_W-1:0] ROM_VAL = sig_entry(g, DEPTH);
        assign w_rom[g] = ROM_VAL;
    end

    logic                  w_en;
    logic                  w_head_bias;
    logic [AW-1:0]         w_head_add;

    // accumulator
    logic [ACC_WIDTH-1:0]  r_acc;
    logic                  r_clip;
    logic [SW-1:0]         w_sum;
    logic                  w_over;
    logic                  w_under;
    logic [ACC_WIDTH-1:0]  w_sat;

    // stage 1: finished sum
    logic                  r_s1_valid;
    logic [ACC_WIDTH-1:0]  r_s1_pre;
    logic                  r_s1_clip;
    logic [CW-1:0]         w_ext;
    logic [CW-1:0]         w_off;
    logic [LUT_SHIFT-1:0]  w_p24;

    // stage 2: table position
    logic                  r_s2_valid;
    logic [ACC_WIDTH-1:0]  r_s2_pre;
    logic                  r_s2_clip;
    logic                  r_s2_below;
    logic                  r_s2_above;
    logic [LUT_SHIFT-1:0]  r_s2_p24;
    logic [LUT_SHIFT+DBW-1:0] w_prod;
    logic [DBW-1:0]        w_idx_raw;

    // stage 3: index and fraction
    logic                  r_s3_valid;
    logic [ACC_WIDTH-1:0]  r_s3_pre;
    logic                  r_s3_clip;
    logic                  r_s3_below;
    logic                  r_s3_above;
    logic [DBW-1:0]        r_s3_idx;
    logic [LUT_SHIFT-1:0]  r_s3_frac;
    logic [LUT_SHIFT:0]    w_rfrac;

    // stage 4: weighted table values
    logic                  r_s4_valid;
    logic [ACC_WIDTH-1:0]  r_s4_pre;
    logic                  r_s4_clip;
    logic                  r_s4_below;
    logic                  r_s4_above;
    logic [MW-1:0]         r_s4_m0;
    logic [MW-1:0]         r_s4_m1;
    logic [MW:0]           w_tot;
    logic [SIG_W-1:0]      w_s16;
    logic [SIG_W:0]        w_act;
    logic [ACT_W-1:0]      n_act;

    // output register
    logic                  r_out_valid;
    logic [ACT_W-1:0]      r_out_act;
    logic [ACC_WIDTH-1:0]  r_out_pre;
    logic                  r_out_clip;

    assign w_en        = !r_out_valid || i_ready;
    assign o_pop       = w_en && !i_empty;
    assign w_head_bias = i_head[AW];
    assign w_head_add  = i_head[AW-1:0];

    // saturating add
    always_comb begin
        w_sum   = {{(SW-ACC_WIDTH){r_acc[ACC_WIDTH-1]}}, r_acc}
                + {{(SW-AW){w_head_add[AW-1]}}, w_head_add};
        w_over  = $signed(w_sum) > $signed(SUM_MAX);
        w_under = $signed(w_sum) < $signed(SUM_MIN);
        if (w_over) begin
            w_sat = SUM_MAX[ACC_WIDTH-1:0];
        end else if (w_under) begin
            w_sat = SUM_MIN[ACC_WIDTH-1:0];
        end else begin
            w_sat = w_sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_clip     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= o_pop && w_head_bias;
            if (o_pop) begin
                if (w_head_bias) begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_acc  <= w_sat;
                    r_clip <= r_clip || w_over || w_under;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pre  <= w_sat;
            r_s1_clip <= r_clip || w_over || w_under;
        end
    end

    // offset by +8, keep 24 fraction bits
    assign w_ext = {{(CW-ACC_WIDTH){r_s1_pre[ACC_WIDTH-1]}}, r_s1_pre};
    assign w_off = w_ext + LIM;

    if (ACC_FRAC >= 24) begin : g_p24_shr
        assign w_p24 = w_off[PW-1 -: LUT_SHIFT];
    end else begin : g_p24_shl
        assign w_p24 = {w_off[PW-1:0], {(24-ACC_FRAC){1'b0}}};
    end

    assign w_prod    = {{DBW{1'b0}}, r_s2_p24} * (LUT_SHIFT+DBW)'(DEPTH);
    assign w_idx_raw = w_prod[LUT_SHIFT+DBW-1:LUT_SHIFT];
    assign w_rfrac   = (LUT_SHIFT+1)'(1) << LUT_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_s4_valid  <= r_s3_valid;
                r_out_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_pre   <= r_s1_pre;
            r_s2_clip  <= r_s1_clip;
            r_s2_below <= $signed(w_ext) < $signed(NEG_LIM);
            r_s2_above <= $signed(w_ext) >= $signed(LIM);
            r_s2_p24   <= w_p24;

            r_s3_pre   <= r_s2_pre;
            r_s3_clip  <= r_s2_clip;
            r_s3_below <= r_s2_below;
            r_s3_above <= r_s2_above;
            r_s3_idx   <= (w_idx_raw >= DBW'(DEPTH)) ? DBW'(DEPTH - 1) : w_idx_raw;
            r_s3_frac  <= w_prod[LUT_SHIFT-1:0];

            r_s4_pre   <= r_s3_pre;
            r_s4_clip  <= r_s3_clip;
            r_s4_below <= r_s3_below;
            r_s4_above <= r_s3_above;
            r_s4_m0    <= MW'(w_rom[r_s3_idx]) * MW'(w_rfrac - {1'b0, r_s3_frac});
            r_s4_m1    <= MW'(w_rom[r_s3_idx + DBW'(1)]) * MW'(r_s3_frac);

            r_out_act  <= n_act;
            r_out_pre  <= r_s4_pre;
            r_out_clip <= r_s4_clip;
        end
    end

    // blend, round, clamp to the table range, then shape per mode
    always_comb begin
        w_tot = {1'b0, r_s4_m0} + {1'b0, r_s4_m1} + ((MW+1)'(1) << (LUT_SHIFT - 1));
        if (r_s4_below) begin
            w_s16 = '0;
        end else if (r_s4_above) begin
            w_s16 = SIG_ONE;
        end else begin
            w_s16 = w_tot[LUT_SHIFT +: SIG_W];
        end
        if (i_mode == MODE_CENTRED) begin
            w_act = {1'b0, w_s16} - {2'b0, SIG_ONE[SIG_W-1:1]};
            if ($signed(w_act) > $signed({3'b0, {(ACT_W-1){1'b1}}})) begin
                n_act = {1'b0, {(ACT_W-1){1'b1}}};
            end else begin
                n_act = w_act[ACT_W-1:0];
            end
        end else begin
            w_act = ({1'b0, w_s16} + (SIG_W+1)'(1)) >> 1;
            if (w_act > {3'b0, {(ACT_W-1){1'b1}}}) begin
                n_act = {1'b0, {(ACT_W-1){1'b1}}};
            end else begin
                n_act = w_act[ACT_W-1:0];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_activation     = r_out_act;
    assign o_pre_activation = r_out_pre;
    assign o_sum_saturated  = r_out_clip;

    a_bias_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && w_head_bias |=> r_acc == '0 && !r_clip)
        else $error("accumulator not cleared after bias transfer");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> r_s3_idx < DBW'(DEPTH))
        else $error("table index out of range");

    a_plain_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_mode == MODE_PLAIN |-> !r_out_act[ACT_W-1])
        else $error("negative plain sigmoid");

endmodule

`default_nettype wire

/* rtl/sigmoid_neuron_mac.sv */
`default_nettype none

// sigmoid_neuron_mac: one neuron evaluated over a stream of transfers.
// Each input transfer carries a feature and a weight (signed Q3.12); their
// product goes into a saturating Q.24 accumulator. A transfer with bias_item
// set adds its weight as the bias, closes the neuron and yields exactly one
// output transfer: the saturated pre-activation sum, a flag that tells if the
// accumulator clipped during this neuron, and the activation in signed Q1.15.
// The accumulator and the flag then clear for the next neuron. The activation
// is the sigmoid, read from an interpolated table over [-8,8) that gives 0
// below and 1.0 (output 32767) at or above; activation_mode = 1 gives
// 2*(sigmoid-0.5) instead. Write activation_mode only while no neuron is in
// flight; the write port is always ready.
// Throughput: one input transfer per cycle, sustained. The front stage holds
// the feature-weight multiplier; a four-entry queue decouples it from the
// accumulator, so output stalls are absorbed by the queue before input
// ready drops. A bias transfer passes the product register on the input
// transfer itself, then queue write, accumulate, offset, index, table
// weighting and blend into the output register. The accumulator loop
// is one add-and-saturate per cycle while the output is not stalled;
// the sigmoid path is pipelined behind it and stalls with the output.

module sigmoid_neuron_mac #(
    parameter int DATA_WIDTH          = snm_pkg::DATA_WIDTH_DEF,
    parameter int ACC_WIDTH           = snm_pkg::ACC_WIDTH_DEF,
    parameter int SIGMOID_TABLE_DEPTH = snm_pkg::SIG_DEPTH_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // configuration write
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire                        i_cfg_activation_mode,
    // input items
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [DATA_WIDTH-1:0]      i_feature,
    input  wire  [DATA_WIDTH-1:0]      i_weight,
    input  wire                        i_bias_item,
    // results
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [snm_pkg::ACT_W-1:0]  o_activation,
    output logic [ACC_WIDTH-1:0]       o_pre_activation,
    output logic                       o_sum_saturated
);
    import snm_pkg::*;

    localparam int QW = 2 * DATA_WIDTH + 1;   // {bias, addend}

    logic          r_mode;
    logic          w_push;
    logic [QW-1:0] w_push_data;
    logic          w_full;
    logic          w_pop;
    logic          w_empty;
    logic [QW-1:0] w_head;

    // mode register, write taken on every valid
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_activation_mode;
        end
    end

    // front: take the transfer, form product or aligned bias
    snm_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_feature   (i_feature),
        .i_weight    (i_weight),
        .i_bias_item (i_bias_item),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    snm_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_empty     (w_empty),
        .o_head      (w_head)
    );

    // back: accumulate, then sigmoid pipeline and output register
    snm_back #(
        .DATA_WIDTH          (DATA_WIDTH),
        .ACC_WIDTH           (ACC_WIDTH),
        .SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_mode           (r_mode),
        .i_head           (w_head),
        .i_empty          (w_empty),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_activation     (o_activation),
        .o_pre_activation (o_pre_activation),
        .o_sum_saturated  (o_sum_saturated)
    );

endmodule

`default_nettype wire
